// File: hdl/ddtw_pkg.sv
package ddtw_pkg;

  localparam int unsigned VALUE_W        = 27;
  localparam int unsigned COUNT_W        = 4;
  localparam int unsigned COORD_W        = 5;
  localparam int unsigned ADDR_W         = 10;
  localparam int unsigned BASE_W         = 10;
  localparam int unsigned TILE_W         = 11;
  localparam int unsigned BCD_W          = 4;
  localparam int unsigned POW_W          = 34;
  localparam int unsigned STEP_W         = 5;
  localparam int unsigned MAX_DIGITS_DEF = 8;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(64);
  localparam logic [BCD_W-1:0]  DIGIT_NINE = BCD_W'(9);
  localparam logic [BCD_W-1:0]  DIGIT_ZERO = BCD_W'(0);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } ddtw_state_e;

  // ten to the power n, for n up to ten
  function automatic logic [POW_W-1:0] pow10_f(input logic [COUNT_W-1:0] n);
    logic [POW_W-1:0] p;
    unique case (n)
      4'd0:    p = POW_W'(64'd1);
      4'd1:    p = POW_W'(64'd10);
      4'd2:    p = POW_W'(64'd100);
      4'd3:    p = POW_W'(64'd1000);
      4'd4:    p = POW_W'(64'd10000);
      4'd5:    p = POW_W'(64'd100000);
      4'd6:    p = POW_W'(64'd1000000);
      4'd7:    p = POW_W'(64'd10000000);
      4'd8:    p = POW_W'(64'd100000000);
      4'd9:    p = POW_W'(64'd1000000000);
      4'd10:   p = POW_W'(64'd10000000000);
      default: p = POW_W'(64'd10000000000);
    endcase
    return p;
  endfunction

endpackage

// File: hdl/decimal_digit_tile_writer.sv
// flow: a beat is taken while idle and its value is shifted msb first through the
//   bcd cell row in 27 steps; then leading zeros are skipped and the digits written
// throughput: one value at a time; the next beat is taken only once the last write
//   of the current value is issued, and an output stall holds the skips and writes
// reset: rst_ni asynchronous, active low; tile_base returns to 64, control idles
module decimal_digit_tile_writer import ddtw_pkg::*; #(
  parameter int unsigned MaxDigits = MAX_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write (tile base)
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [BASE_W-1:0]  cfg_data_i,
  // input beat
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [COUNT_W-1:0] digit_count_i,
  input  logic [COORD_W-1:0] column_i,
  input  logic [COORD_W-1:0] row_i,
  // output beat (one map write)
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ADDR_W-1:0]  map_address_o,
  output logic [TILE_W-1:0]  tile_word_o,
  output logic               last_write_o
);

  // digit position index, one bit at least
  localparam int unsigned PosW = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  localparam logic [COUNT_W-1:0] MaxCnt = COUNT_W'(MaxDigits);

  ddtw_state_e state_q, state_d;

  logic [BASE_W-1:0]  base_q;
  logic [VALUE_W-1:0] val_q, val_d;       // binary value, shifted out msb first
  logic [STEP_W-1:0]  step_q, step_d;     // conversion steps left
  logic [PosW-1:0]    pos_q, pos_d;       // digit position being examined
  logic [PosW-1:0]    wr_q, wr_d;         // writes already issued
  logic [ADDR_W-1:0]  origin_q, origin_d; // row * 32 + column
  logic               sat_q, sat_d;       // value too wide, show nines
  logic               start_q, start_d;   // first non-zero digit seen

  logic               ov_q, ov_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [TILE_W-1:0]  tile_q, tile_d;
  logic               last_q, last_d;

  logic               accept;
  logic               cell_clear;
  logic               cell_shift;
  logic [COUNT_W-1:0] cnt_clamped;
  logic [BCD_W-1:0]   digit_sel;
  logic               slot_free;

  logic [BCD_W-1:0]   digit_w [MaxDigits];
  logic [MaxDigits:0] carry_w;

  // configuration is always taken; users send writes only while idle (unenforced)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_valid_i) begin
      base_q <= cfg_data_i;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // clamp the digit count to 1..MaxDigits
  always_comb begin
    if (digit_count_i == '0) begin
      cnt_clamped = COUNT_W'(1);
    end else if (digit_count_i > MaxCnt) begin
      cnt_clamped = MaxCnt;
    end else begin
      cnt_clamped = digit_count_i;
    end
  end

  // row of bcd cells, the lowest digit takes the value's msb each step
  assign carry_w[0] = val_q[VALUE_W-1];

  for (genvar g = 0; g < MaxDigits; g++) begin : g_cell
    ddtw_cell u_cell (
      .clk_i   (clk_i),
      .clear_i (cell_clear),
      .shift_i (cell_shift),
      .bit_i   (carry_w[g]),
      .bit_o   (carry_w[g+1]),
      .digit_o (digit_w[g])
    );
  end

  // saturated values show nines in every place
  assign digit_sel = sat_q ? DIGIT_NINE : digit_w[pos_q];
  assign slot_free = !ov_q || out_ready_i;

  assign cell_clear = accept;
  assign cell_shift = (state_q == ST_CONV);

  always_comb begin
    state_d  = state_q;
    val_d    = val_q;
    step_d   = step_q;
    pos_d    = pos_q;
    wr_d     = wr_q;
    origin_d = origin_q;
    sat_d    = sat_q;
    start_d  = start_q;
    ov_d     = ov_q && !out_ready_i;
    addr_d   = addr_q;
    tile_d   = tile_q;
    last_d   = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d    = value_i;
          step_d   = STEP_W'(VALUE_W);
          pos_d    = PosW'(cnt_clamped - COUNT_W'(1));
          wr_d     = '0;
          origin_d = {row_i, column_i};
          sat_d    = {{(POW_W-VALUE_W){1'b0}}, value_i} >= pow10_f(cnt_clamped);
          start_d  = 1'b0;
          state_d  = ST_CONV;
        end
      end
      ST_CONV: begin
        val_d  = {val_q[VALUE_W-2:0], 1'b0};
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          // leading zero: skip it, the units digit is always written
          if (!start_q && digit_sel == DIGIT_ZERO && pos_q != '0) begin
            pos_d = pos_q - PosW'(1);
          end else begin
            ov_d    = 1'b1;
            addr_d  = origin_q + ADDR_W'(wr_q);
            tile_d  = TILE_W'(base_q) + TILE_W'(digit_sel);
            last_d  = (pos_q == '0);
            start_d = 1'b1;
            wr_d    = wr_q + PosW'(1);
            if (pos_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              pos_d = pos_q - PosW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    step_q   <= step_d;
    pos_q    <= pos_d;
    wr_q     <= wr_d;
    origin_q <= origin_d;
    sat_q    <= sat_d;
    start_q  <= start_d;
    addr_q   <= addr_d;
    tile_q   <= tile_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = ov_q;
  assign map_address_o = addr_q;
  assign tile_word_o   = tile_q;
  assign last_write_o  = last_q;

endmodule

// File: hdl/ddtw_cell.sv
module ddtw_cell import ddtw_pkg::*; (
  input  logic             clk_i,
  input  logic             clear_i,
  input  logic             shift_i,
  input  logic             bit_i,
  output logic             bit_o,
  output logic [BCD_W-1:0] digit_o
);

  logic [BCD_W-1:0] digit_q, digit_d;
  logic [BCD_W-1:0] adj;

  // add three before the shift when the digit is five or more
  always_comb begin
    adj = (digit_q >= BCD_W'(5)) ? digit_q + BCD_W'(3) : digit_q;
    bit_o = adj[BCD_W-1];
    digit_d = digit_q;
    if (clear_i) begin
      digit_d = DIGIT_ZERO;
    end else if (shift_i) begin
      digit_d = {adj[BCD_W-2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

// File: hdl/ddtw_checker.sv
module ddtw_checker import ddtw_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_ready_o,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [ADDR_W-1:0]  map_address_o,
  input logic [TILE_W-1:0]  tile_word_o,
  input logic               last_write_o
);

  // a stalled write beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(map_address_o)
      && $stable(tile_word_o) && $stable(last_write_o))
    else $error("output beat changed while stalled");

  // one value at a time: no new input right after one is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // while a non-final write is pending, more writes follow, so input is held off
  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_write_o |-> !in_ready_o)
    else $error("input ready during a value's writes");

  // consecutive writes of one value land on consecutive map entries, back to back
  a_addr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_write_o |=>
      out_valid_o && map_address_o == $past(map_address_o) + ADDR_W'(1))
    else $error("map writes of one value not on consecutive entries");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind decimal_digit_tile_writer ddtw_checker u_ddtw_checker (.*);
